// File: design/gfma_pkg.sv
// Shared constants for the position-fix moving-average filter.
`default_nettype none

package gfma_pkg;

    // Field widths of one fix
    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int ALT_W = 25;

    // Default window length and altitude ceiling after reset (cm)
    localparam int WINDOW_DEF = 8;
    localparam logic signed [ALT_W-1:0] ALT_CEIL_RESET = 25'sd10000000;

    // Quotient bits retired per divider cycle
    localparam int DIV_STEPS = 4;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 184;

endpackage

`default_nettype wire

// File: design/gfma_cell.sv
// One window cell: holds a sample and hands it to the next cell on a push.
`default_nettype none

module gfma_cell #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         shift,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] sample_reg;
    logic [W-1:0] sample_next;

    // Load the neighbor's sample on a push, else hold
    always_comb begin
        sample_next = shift ? d : sample_reg;
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

// File: design/gfma_div.sv
// Iterative signed divider, truncating toward zero, several quotient bits per cycle.
`default_nettype none

module gfma_div #(
    parameter int DIV_W  = 35,
    parameter int FILL_W = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [DIV_W-1:0] dividend,
    input  wire logic [FILL_W-1:0]       divisor,
    output logic                         done,
    output logic signed [DIV_W-1:0]      quotient
);
    import gfma_pkg::*;

    localparam int CYC   = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W = CYC * DIV_STEPS;
    localparam int CNT_W = $clog2(CYC + 1);

    logic [PAD_W-1:0]  mag_reg, mag_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] dsr_reg, dsr_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_W-1:0]  abs_val;
    logic [PAD_W-1:0]  step_mag;
    logic [FILL_W-1:0] step_rem;
    logic [FILL_W:0]   trial;
    logic [PAD_W-1:0]  signed_q;

    // Magnitude of the dividend
    assign abs_val = dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;

    // Restoring steps: remainder stays narrow, below the divisor
    always_comb begin
        step_mag = mag_reg;
        step_rem = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {step_rem, step_mag[PAD_W-1]};
            if (trial >= {1'b0, dsr_reg}) begin
                step_rem = FILL_W'(trial - {1'b0, dsr_reg});
                step_mag = {step_mag[PAD_W-2:0], 1'b1};
            end else begin
                step_rem = trial[FILL_W-1:0];
                step_mag = {step_mag[PAD_W-2:0], 1'b0};
            end
        end
    end

    // Sequencing
    always_comb begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            mag_next  = PAD_W'(abs_val);
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[DIV_W-1];
            cnt_next  = CNT_W'(CYC);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            mag_next = step_mag;
            rem_next = step_rem;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    // Restore the sign
    assign signed_q = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign quotient = signed_q[DIV_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: design/gfma_cell_chain_dummy_removed.sv
// Window length helper: counts held samples and flags a full window.
`default_nettype none

module gfma_fill #(
    parameter int WINDOW = 8,
    parameter int FILL_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    output logic [FILL_W-1:0]      fill,
    output logic                   full
);

    logic [FILL_W-1:0] fill_reg, fill_next;

    // Saturating count of samples in the window
    always_comb begin
        fill_next = fill_reg;
        if (push && (fill_reg != FILL_W'(WINDOW))) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign fill = fill_reg;
    assign full = (fill_reg == FILL_W'(WINDOW));

endmodule

`default_nettype wire

// File: design/gps_fix_moving_average_top.sv
// Top level of the position-fix moving-average filter.
//
// Each input beat carries one fix (latitude, longitude, altitude, each with a
// valid flag; an invalid value counts as zero). Latitude and longitude always
// enter boxcar windows of the last WINDOW samples; altitude enters its own
// window only when strictly below the ceiling register, otherwise the last
// altitude mean is held (zero until an altitude is taken). Each window is a
// row of cells that shift on a push, with a running sum beside it. The means
// come from one shared divider that retires four quotient bits per cycle. One
// item passes through its accept, then two or three divisions (three when the
// altitude is taken), each issued from a start state and awaited in a wait
// state, then an output state that loads the output register. The next item is
// accepted while a finished result waits on the output. The ceiling register
// may be written only while the block is idle.
`default_nettype none

module gps_fix_moving_average_top #(
    parameter int WINDOW = gfma_pkg::WINDOW_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write: altitude ceiling (cm, signed)
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gfma_pkg::ALT_W-1:0]     cfg_data,
    // Input fix, tdata from bit 0: lat_value, lat_ok, lon_value, lon_ok,
    // alt_value, alt_ok, zero pad
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gfma_pkg::S_DATA_W-1:0]  s_tdata,
    // Result, tdata from bit 0: lat_used, lon_used, alt_used, lat_mean,
    // lon_mean, alt_mean, alt_taken, zero pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [gfma_pkg::M_DATA_W-1:0]       m_tdata
);
    import gfma_pkg::*;

    localparam int LOG_W     = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int LAT_SUM_W = LAT_W + LOG_W;
    localparam int LON_SUM_W = LON_W + LOG_W;
    localparam int ALT_SUM_W = ALT_W + LOG_W;
    localparam int DIV_W     = LON_SUM_W;

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;

    // Channel codes for the shared divider
    localparam logic [1:0] CH_LAT = 2'd0;
    localparam logic [1:0] CH_LON = 2'd1;
    localparam logic [1:0] CH_ALT = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    logic signed [ALT_W-1:0]     ceil_reg;
    logic signed [LAT_SUM_W-1:0] lat_total_reg, lat_total_next;
    logic signed [LON_SUM_W-1:0] lon_total_reg, lon_total_next;
    logic signed [ALT_SUM_W-1:0] alt_total_reg, alt_total_next;

    logic [LAT_W-1:0] lat_used_reg;
    logic [LON_W-1:0] lon_used_reg;
    logic [ALT_W-1:0] alt_used_reg;
    logic             taken_reg;
    logic [LAT_W-1:0] lat_mean_reg;
    logic [LON_W-1:0] lon_mean_reg;
    logic [ALT_W-1:0] alt_held_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             accept;
    logic [LAT_W-1:0] lat_in;
    logic [LON_W-1:0] lon_in;
    logic [ALT_W-1:0] alt_in;
    logic             alt_take;

    logic [LAT_W-1:0] lat_q [WINDOW];
    logic [LON_W-1:0] lon_q [WINDOW];
    logic [ALT_W-1:0] alt_q [WINDOW];

    logic [FILL_W-1:0] pos_fill;
    logic [FILL_W-1:0] alt_fill;
    logic              pos_full;
    logic              alt_full;

    logic                    div_start;
    logic signed [DIV_W-1:0] div_dividend;
    logic [FILL_W-1:0]       div_divisor;
    logic                    div_done;
    logic signed [DIV_W-1:0] div_quot;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Unpack and substitute zero for invalid values
    assign lat_in   = s_tdata[31] ? s_tdata[30:0] : '0;
    assign lon_in   = s_tdata[64] ? s_tdata[63:32] : '0;
    assign alt_in   = s_tdata[90] ? s_tdata[89:65] : '0;
    assign alt_take = $signed(alt_in) < ceil_reg;

    // Window cell rows, cell 0 takes the new sample, the last holds the oldest
    for (genvar i = 0; i < WINDOW; i++) begin : g_cells
        if (i == 0) begin : g_head
            gfma_cell #(.W(LAT_W)) u_lat (
                .aclk(aclk), .shift(accept), .d(lat_in), .q(lat_q[i]));
            gfma_cell #(.W(LON_W)) u_lon (
                .aclk(aclk), .shift(accept), .d(lon_in), .q(lon_q[i]));
            gfma_cell #(.W(ALT_W)) u_alt (
                .aclk(aclk), .shift(accept && alt_take), .d(alt_in), .q(alt_q[i]));
        end else begin : g_body
            gfma_cell #(.W(LAT_W)) u_lat (
                .aclk(aclk), .shift(accept), .d(lat_q[i-1]), .q(lat_q[i]));
            gfma_cell #(.W(LON_W)) u_lon (
                .aclk(aclk), .shift(accept), .d(lon_q[i-1]), .q(lon_q[i]));
            gfma_cell #(.W(ALT_W)) u_alt (
                .aclk(aclk), .shift(accept && alt_take), .d(alt_q[i-1]),
                .q(alt_q[i]));
        end
    end

    // Fill counts
    gfma_fill #(.WINDOW(WINDOW), .FILL_W(FILL_W)) u_pos_fill (
        .aclk(aclk), .aresetn(aresetn), .push(accept),
        .fill(pos_fill), .full(pos_full));

    gfma_fill #(.WINDOW(WINDOW), .FILL_W(FILL_W)) u_alt_fill (
        .aclk(aclk), .aresetn(aresetn), .push(accept && alt_take),
        .fill(alt_fill), .full(alt_full));

    // Running sums: add the new sample, drop the evicted one once full
    always_comb begin
        lat_total_next = lat_total_reg;
        lon_total_next = lon_total_reg;
        alt_total_next = alt_total_reg;
        if (accept) begin
            lat_total_next = lat_total_reg + LAT_SUM_W'($signed(lat_in))
                - (pos_full ? LAT_SUM_W'($signed(lat_q[WINDOW-1])) : '0);
            lon_total_next = lon_total_reg + LON_SUM_W'($signed(lon_in))
                - (pos_full ? LON_SUM_W'($signed(lon_q[WINDOW-1])) : '0);
            if (alt_take) begin
                alt_total_next = alt_total_reg + ALT_SUM_W'($signed(alt_in))
                    - (alt_full ? ALT_SUM_W'($signed(alt_q[WINDOW-1])) : '0);
            end
        end
    end

    // Divider operand select
    always_comb begin
        div_dividend = DIV_W'(lat_total_reg);
        div_divisor  = pos_fill;
        case (ch_reg)
            CH_LAT: begin
                div_dividend = DIV_W'(lat_total_reg);
                div_divisor  = pos_fill;
            end
            CH_LON: begin
                div_dividend = DIV_W'(lon_total_reg);
                div_divisor  = pos_fill;
            end
            CH_ALT: begin
                div_dividend = DIV_W'(alt_total_reg);
                div_divisor  = alt_fill;
            end
            default: begin
                div_dividend = DIV_W'(lat_total_reg);
                div_divisor  = pos_fill;
            end
        endcase
    end

    assign div_start = (state_reg == ST_START);

    gfma_div #(.DIV_W(DIV_W), .FILL_W(FILL_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(div_divisor),
        .done(div_done), .quotient(div_quot));

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_START;
                    ch_next    = CH_LAT;
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (ch_reg == CH_LAT) begin
                        ch_next    = CH_LON;
                        state_next = ST_START;
                    end else if (ch_reg == CH_LON && taken_reg) begin
                        ch_next    = CH_ALT;
                        state_next = ST_START;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({taken_reg, alt_held_reg, lon_mean_reg,
                        lat_mean_reg, alt_used_reg, lon_used_reg, lat_used_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg        <= CH_LAT;
            ceil_reg      <= ALT_CEIL_RESET;
            lat_total_reg <= '0;
            lon_total_reg <= '0;
            alt_total_reg <= '0;
            alt_held_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            lat_total_reg <= lat_total_next;
            lon_total_reg <= lon_total_next;
            alt_total_reg <= alt_total_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                ceil_reg <= cfg_data;
            end
            if (state_reg == ST_WAIT && div_done && ch_reg == CH_ALT) begin
                alt_held_reg <= div_quot[ALT_W-1:0];
            end
        end
    end

    // Item payload and means
    always_ff @(posedge aclk) begin
        if (accept) begin
            lat_used_reg <= lat_in;
            lon_used_reg <= lon_in;
            alt_used_reg <= alt_in;
            taken_reg    <= alt_take;
        end
        if (state_reg == ST_WAIT && div_done && ch_reg == CH_LAT) begin
            lat_mean_reg <= div_quot[LAT_W-1:0];
        end
        if (state_reg == ST_WAIT && div_done && ch_reg == CH_LON) begin
            lon_mean_reg <= div_quot[LON_W-1:0];
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: test/gps_fix_moving_average_top_test.sv
// Testbench for the position-fix moving-average filter: streams fixes, predicts means, checks.
`timescale 1ns / 1ps

module gps_fix_moving_average_top_test;
    import gfma_pkg::*;

    localparam int WINDOW      = WINDOW_DEF;
    localparam int DRAIN_PAUSE = 60;    // cycles after the last result, covers one item
    localparam int STALL_LEN   = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS = 175;

    localparam longint LAT_LIM  = 900000000;
    localparam longint LON_LIM  = 1800000000;
    localparam longint ALT_LOW  = -1000000;
    localparam longint ALT_HIGH = 10000000;
    localparam longint ALT_WMIN = -(longint'(1) << (ALT_W - 1));
    localparam longint ALT_WMAX = (longint'(1) << (ALT_W - 1)) - 1;

    typedef enum int {CH_LAT, CH_LON, CH_ALT} chan_t;

    // One fix as it goes into the block
    typedef struct {
        logic signed [LAT_W-1:0] lat_value;
        logic                    lat_ok;
        logic signed [LON_W-1:0] lon_value;
        logic                    lon_ok;
        logic signed [ALT_W-1:0] alt_value;
        logic                    alt_ok;
    } fix_t;

    // Result beat, laid out as m_tdata (first member is the top)
    typedef struct packed {
        logic [6:0]       pad;
        logic             alt_taken;
        logic [ALT_W-1:0] alt_mean;
        logic [LON_W-1:0] lon_mean;
        logic [LAT_W-1:0] lat_mean;
        logic [ALT_W-1:0] alt_used;
        logic [LON_W-1:0] lon_used;
        logic [LAT_W-1:0] lat_used;
    } means_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ALT_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    gps_fix_moving_average_top #(.WINDOW(WINDOW)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: three ring windows with running sums, plus held altitude mean
    longint                  win_data [3][WINDOW];
    int                      win_slot [3];
    int                      win_fill [3];
    longint                  win_total[3];
    longint                  alt_held_mean;
    logic signed [ALT_W-1:0] alt_ceiling = ALT_CEIL_RESET;

    means_t pending_means[$];

    int  error_count     = 0;
    int  fixes_sent      = 0;
    int  results_checked = 0;
    int  alt_taken_seen  = 0;
    int  ceiling_writes  = 0;
    bit  tx_quiet        = 1'b0;
    bit  rx_quiet        = 1'b0;
    int  rx_hold_cycles  = 0;

    // Track used to build realistic drifting fixes
    longint track_lat = 473000000;
    longint track_lon = 85000000;
    longint track_alt = 50000;

    function automatic longint window_push(chan_t ch, longint v);
        int s;
        s = win_slot[ch];
        if (win_fill[ch] >= WINDOW)
            win_total[ch] -= win_data[ch][s];
        else
            win_fill[ch]++;
        win_data[ch][s] = v;
        win_total[ch] += v;
        win_slot[ch] = (s + 1) % WINDOW;
        return win_total[ch] / longint'(win_fill[ch]);
    endfunction

    // Expected beat for one accepted fix; advances the windows
    function automatic means_t predict_fix_means(fix_t f);
        means_t r;
        longint lat, lon, alt, m;
        lat = f.lat_ok ? longint'(f.lat_value) : 0;
        lon = f.lon_ok ? longint'(f.lon_value) : 0;
        alt = f.alt_ok ? longint'(f.alt_value) : 0;
        r = '0;
        r.lat_used = lat[LAT_W-1:0];
        r.lon_used = lon[LON_W-1:0];
        r.alt_used = alt[ALT_W-1:0];
        m = window_push(CH_LAT, lat);
        r.lat_mean = m[LAT_W-1:0];
        m = window_push(CH_LON, lon);
        r.lon_mean = m[LON_W-1:0];
        if (alt < longint'(alt_ceiling)) begin
            alt_held_mean = window_push(CH_ALT, alt);
            r.alt_taken = 1'b1;
        end
        r.alt_mean = alt_held_mean[ALT_W-1:0];
        return r;
    endfunction

    function automatic longint rand_span(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo), 0));
    endfunction

    function automatic fix_t make_fix(longint lat, bit lat_ok, longint lon, bit lon_ok,
                                      longint alt, bit alt_ok);
        fix_t f;
        f.lat_value = lat[LAT_W-1:0];
        f.lat_ok    = lat_ok;
        f.lon_value = lon[LON_W-1:0];
        f.lon_ok    = lon_ok;
        f.alt_value = alt[ALT_W-1:0];
        f.alt_ok    = alt_ok;
        return f;
    endfunction

    // Mostly a drifting track, some uniform fixes, some raw bit patterns
    function automatic fix_t random_fix();
        longint lat, lon, alt;
        int     pick;
        pick = $urandom_range(99, 0);
        if (pick < 60) begin
            track_lat += rand_span(-500, 500);
            track_lon += rand_span(-500, 500);
            lat = track_lat + rand_span(-40, 40);
            lon = track_lon + rand_span(-40, 40);
        end else if (pick < 85) begin
            lat = rand_span(-LAT_LIM, LAT_LIM);
            lon = rand_span(-LON_LIM, LON_LIM);
        end else begin
            lat = longint'($urandom);
            lon = longint'($urandom);
        end
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
            alt = longint'(alt_ceiling) + rand_span(-20, 20);
        end else if (pick < 65) begin
            track_alt += rand_span(-300, 300);
            alt = track_alt;
        end else if (pick < 90) begin
            alt = rand_span(ALT_LOW, ALT_HIGH);
        end else begin
            alt = longint'($urandom);
        end
        return make_fix(lat, $urandom_range(9, 0) != 0, lon, $urandom_range(9, 0) != 0,
                        alt, $urandom_range(9, 0) != 0);
    endfunction

    // Offer one fix; tvalid stays high afterward unless a gap is drawn next time
    task automatic send_fix(input fix_t f);
        int gap;
        @(negedge aclk);
        gap = tx_quiet ? 0 : $urandom_range(4, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {5'b0, f.alt_ok, f.alt_value, f.lon_ok, f.lon_value,
                     f.lat_ok, f.lat_value};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_means.push_back(predict_fix_means(f));
        fixes_sent++;
    endtask

    task automatic end_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    // Ceiling write; caller makes sure the block is idle
    task automatic write_ceiling(input longint v);
        @(negedge aclk);
        cfg_data  <= v[ALT_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        alt_ceiling = v[ALT_W-1:0];
        ceiling_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ceiling_idle(input longint v);
        end_input();
        wait_drained();
        write_ceiling(v);
    endtask

    function automatic void report_failure(string msg);
        if (error_count < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got)
            report_failure($sformatf("beat %0d %s expected 0x%0h got 0x%0h",
                                     results_checked, name, want, got));
    endfunction

    // Result checker: every accepted beat against the oldest prediction
    always @(posedge aclk) begin
        means_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_means.size() == 0) begin
                report_failure($sformatf("unexpected result beat 0x%0h", m_tdata));
            end else begin
                want = pending_means.pop_front();
                compare_field("lat_used", want.lat_used, got.lat_used);
                compare_field("lon_used", want.lon_used, got.lon_used);
                compare_field("alt_used", want.alt_used, got.alt_used);
                compare_field("lat_mean", want.lat_mean, got.lat_mean);
                compare_field("lon_mean", want.lon_mean, got.lon_mean);
                compare_field("alt_mean", want.alt_mean, got.alt_mean);
                compare_field("alt_taken", want.alt_taken, got.alt_taken);
                compare_field("pad", want.pad, got.pad);
                if (want.alt_taken)
                    alt_taken_seen++;
            end
            results_checked++;
        end
    end

    // Result receiver: random hold-offs, one long stall on request
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            gap = rx_quiet ? 0 : $urandom_range(4, 0);
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Field extremes at the reset ceiling, windows filled past WINDOW and wrapped
    task automatic test_field_extremes();
        longint lat_wmax, lon_wmax;
        lat_wmax = (longint'(1) << (LAT_W - 1)) - 1;
        lon_wmax = (longint'(1) << (LON_W - 1)) - 1;
        // altitude equal to the ceiling is rejected; mean still zero
        send_fix(make_fix(LAT_LIM, 1, LON_LIM, 1, ALT_HIGH, 1));
        send_fix(make_fix(-LAT_LIM, 1, -LON_LIM, 1, ALT_LOW, 1));
        send_fix(make_fix(lat_wmax, 1, lon_wmax, 1, ALT_WMAX, 1));
        send_fix(make_fix(-lat_wmax - 1, 1, -lon_wmax - 1, 1, ALT_WMIN, 1));
        // invalid values with all bits set must read as zero
        send_fix(make_fix(-1, 0, -1, 0, -1, 0));
        send_fix(make_fix(LAT_LIM, 1, -1, 0, 22369621, 0));
        send_fix(make_fix(-1, 0, -LON_LIM, 1, ALT_HIGH - 1, 1));
        for (int i = 0; i < 5; i++) begin
            if (i % 2 == 0)
                send_fix(make_fix(lat_wmax, 1, lon_wmax, 1, ALT_WMAX - 1, 1));
            else
                send_fix(make_fix(-lat_wmax - 1, 1, -lon_wmax - 1, 1, ALT_WMIN, 1));
        end
    endtask

    // Strict comparison against the ceiling, invalid altitude tested as zero
    task automatic test_ceiling_edges();
        set_ceiling_idle(0);
        send_fix(make_fix(1, 1, 1, 1, 0, 1));
        send_fix(make_fix(2, 1, 2, 1, 12345, 0));
        send_fix(make_fix(3, 1, 3, 1, -1, 1));
        set_ceiling_idle(ALT_LOW);
        send_fix(make_fix(4, 1, 4, 1, ALT_LOW, 1));
        send_fix(make_fix(5, 1, 5, 1, ALT_LOW - 1, 1));
    endtask

    // Receiver stalls for a long stretch while fixes keep coming
    task automatic test_output_stall();
        set_ceiling_idle(ALT_HIGH);
        tx_quiet = 1'b1;
        rx_hold_cycles = STALL_LEN;
        for (int i = 0; i < 40; i++)
            send_fix(random_fix());
        tx_quiet = 1'b0;
    endtask

    // Random tracks across several ceiling settings, with gap-free stretches
    task automatic test_random_tracks();
        longint ceilings[8];
        ceilings = '{ALT_HIGH, 0, ALT_LOW, ALT_WMAX, 0, 0, ALT_WMIN, 0};
        ceilings[1] = rand_span(ALT_LOW, ALT_HIGH);
        ceilings[4] = rand_span(ALT_LOW, ALT_HIGH);
        ceilings[7] = rand_span(-100000, 100000);
        foreach (ceilings[p]) begin
            set_ceiling_idle(ceilings[p]);
            track_alt = ceilings[p] + rand_span(-2000, 2000);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                tx_quiet = (i >= 40 && i < 80);
                rx_quiet = (i >= 40 && i < 80);
                send_fix(random_fix());
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        foreach (win_slot[c]) begin
            win_slot[c]  = 0;
            win_fill[c]  = 0;
            win_total[c] = 0;
        end
        alt_held_mean = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_ceiling_edges();
        test_output_stall();
        test_random_tracks();

        end_input();
        wait_drained();
        if (pending_means.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_means.size()));

        $display("Run covered %0d fixes and %0d result beats over %0d ceiling settings.",
                 fixes_sent, results_checked, ceiling_writes);
        $display("Altitude entered its window %0d times and was held %0d times; %0d errors.",
                 alt_taken_seen, results_checked - alt_taken_seen, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #5000000;
        $display("Timeout with %0d results outstanding", pending_means.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
